// ===== hdl/ggp_pkg.sv =====
// ----------------------------------------------------------------------------
// ggp_pkg
// Shared widths, types and constant functions of the go-to-goal controller.
// ----------------------------------------------------------------------------
package ggp_pkg;

  // Field widths.
  localparam int unsigned POS_W     = 24;
  localparam int unsigned HEAD_W    = 19;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned GAIN_FRAC = 8;
  localparam int unsigned SPD_W     = 23;
  localparam int unsigned TURN_W    = 19;

  // Configuration port.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Datapath widths.
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned SQ_W       = 2 * DIFF_W - 2;
  localparam int unsigned RAD_W      = 2 * DIFF_W;
  localparam int unsigned ROOT_W     = DIFF_W;
  localparam int unsigned REM_W      = ROOT_W + 1;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned PAD_SHIFT  = 16;
  localparam int unsigned CX_W       = DIFF_W + PAD_SHIFT + 3;
  localparam int unsigned CORDIC_MAX = 24;
  localparam int unsigned PROD_W     = GAIN_W + ROOT_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam longint TURN_MAX = (longint'(1) << TURN_W) - 1;

  // Defaults for the top-level parameters.
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Arctangent of 2^-i in Q30 for the first steps; later steps use 2^-i.
  localparam longint ATAN_Q30 [11] = '{
    64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159, 64'd67021687,
    64'd33543516, 64'd16775851, 64'd8388437, 64'd4194283, 64'd2097149,
    64'd1048576
  };
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    REG_TARGET_X    = 2'd0,
    REG_TARGET_Y    = 2'd1,
    REG_GAIN        = 2'd2,
    REG_SPEED_LIMIT = 2'd3
  } ggp_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic [GAIN_W-1:0]       gain;
    logic [SPD_W-1:0]        speed_limit;
  } ggp_cfg_t;

  // One classified request on its way from the front end to the back end.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [HEAD_W-1:0] heading;
    logic                     dx_neg;
    logic                     dy_neg;
  } ggp_item_t;

  // Rounds a Q30 angle to frac_bits fraction bits.
  function automatic longint q30_to_frac(longint v, int unsigned frac_bits);
    int unsigned sh;
    sh = 30 - frac_bits;
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint atan_frac(int unsigned i, int unsigned frac_bits);
    longint v;
    if (i <= 10) begin
      v = ATAN_Q30[i[3:0]];
    end else begin
      v = longint'(1) << (30 - i);
    end
    return q30_to_frac(v, frac_bits);
  endfunction

endpackage

// ===== hdl/goto_goal_p_controller.sv =====
// ----------------------------------------------------------------------------
// goto_goal_p_controller
// Proportional go-to-goal controller with an APB register file.
// ----------------------------------------------------------------------------
// A pose request (pos_x_i, pos_y_i, heading_i) is taken at each rising edge
// where start is high and busy is low, one per clock cycle. Its velocity
// command appears on linear_speed_o and turn_rate_o for exactly one cycle,
// flagged by done_o; the receiver cannot hold it off, so it must capture it
// then. The request passes the input register, the request queue, the
// squaring stage, the stage that sums the squares, the square-root pipeline,
// which takes one root bit per stage over 25 stages, the gain multiply and the
// output register; the CORDIC vectoring runs in the same stages. The back end
// drains one request per cycle, so busy stays low in operation. The user must
// write registers (target_x, target_y, gain, speed_limit at byte addresses 0,
// 4, 8, 12) only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module goto_goal_p_controller
  import ggp_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [HEAD_W-1:0] heading_i,
  output logic                     done_o,
  output logic [SPD_W-1:0]         linear_speed_o,
  output logic [TURN_W-1:0]        turn_rate_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam logic [POS_W-1:0] RST_TARGET = POS_W'(longint'(1) << FRAC_BITS);
  localparam logic [SPD_W-1:0] RST_LIMIT  = SPD_W'(longint'(2) << FRAC_BITS);
  localparam logic [GAIN_W-1:0] RST_GAIN  = GAIN_W'(1 << GAIN_FRAC);

  ggp_cfg_t  cfg_q, cfg_d;
  ggp_reg_e  reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = ggp_reg_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_TARGET_X:    cfg_d.target_x    = pwdata[POS_W-1:0];
        REG_TARGET_Y:    cfg_d.target_y    = pwdata[POS_W-1:0];
        REG_GAIN:        cfg_d.gain        = pwdata[GAIN_W-1:0];
        REG_SPEED_LIMIT: cfg_d.speed_limit = pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_x    <= RST_TARGET;
      cfg_q.target_y    <= RST_TARGET;
      cfg_q.gain        <= RST_GAIN;
      cfg_q.speed_limit <= RST_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TARGET_X:    prdata = DATA_W'(cfg_q.target_x);
      REG_TARGET_Y:    prdata = DATA_W'(cfg_q.target_y);
      REG_GAIN:        prdata = DATA_W'(cfg_q.gain);
      REG_SPEED_LIMIT: prdata = DATA_W'(cfg_q.speed_limit);
      default:         prdata = '0;
    endcase
  end

  logic      push, full, empty;
  ggp_item_t push_item, pop_item;

  ggp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .start_i   (start),
    .busy_o    (busy),
    .pos_x_i   (pos_x_i),
    .pos_y_i   (pos_y_i),
    .heading_i (heading_i),
    .full_i    (full),
    .push_o    (push),
    .item_o    (push_item)
  );

  ggp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (~empty),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  ggp_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .valid_i        (~empty),
    .item_i         (pop_item),
    .done_o         (done_o),
    .linear_speed_o (linear_speed_o),
    .turn_rate_o    (turn_rate_o)
  );

endmodule

// ===== hdl/ggp_front.sv =====
// ----------------------------------------------------------------------------
// ggp_front
// Takes pose requests, forms the position error and its quadrant flags.
// ----------------------------------------------------------------------------
module ggp_front
  import ggp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ggp_cfg_t                 cfg_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [HEAD_W-1:0] heading_i,
  input  logic                     full_i,
  output logic                     push_o,
  output ggp_item_t                item_o
);

  logic      valid_q, valid_d;
  ggp_item_t item_q, item_d;
  logic      accept;

  assign busy_o = valid_q & full_i;
  assign accept = start_i & ~busy_o;
  assign push_o = valid_q & ~full_i;
  assign item_o = item_q;

  always_comb begin
    item_d.dx      = DIFF_W'(cfg_i.target_x) - DIFF_W'(pos_x_i);
    item_d.dy      = DIFF_W'(cfg_i.target_y) - DIFF_W'(pos_y_i);
    item_d.heading = heading_i;
    item_d.dx_neg  = item_d.dx[DIFF_W-1];
    item_d.dy_neg  = item_d.dy[DIFF_W-1];
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hdl/ggp_queue.sv =====
// ----------------------------------------------------------------------------
// ggp_queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module ggp_queue
  import ggp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ggp_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output ggp_item_t pop_item_o,
  output logic      empty_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  ggp_item_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;

  assign full_o     = (count_q == CW'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

// ===== hdl/ggp_back.sv =====
// ----------------------------------------------------------------------------
// ggp_back
// Pipelined square root and CORDIC vectoring, then the steering decision.
// ----------------------------------------------------------------------------
module ggp_back
  import ggp_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ggp_cfg_t          cfg_i,
  input  logic              valid_i,
  input  ggp_item_t         item_i,
  output logic              done_o,
  output logic [SPD_W-1:0]  linear_speed_o,
  output logic [TURN_W-1:0] turn_rate_o
);

  localparam int unsigned CN = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;
  localparam int unsigned ZW = FRAC_BITS + 3;
  localparam int unsigned EW = ((ZW > HEAD_W) ? ZW : HEAD_W) + 1;
  localparam int unsigned NS = SQRT_STEPS + 1;
  localparam int unsigned LIN_W = PROD_W - GAIN_FRAC;
  localparam longint THR_DIST = ((longint'(1) << FRAC_BITS) + 5) / 10;
  localparam longint THR_TURN = ((longint'(2) << FRAC_BITS) + 5) / 10;
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(q30_to_frac(HALF_PI_Q30, FRAC_BITS));

  // Entry stage: squares of the error and quadrant pre-rotation.
  logic                     a_v_q;
  logic [SQ_W-1:0]          a_sqx_q, a_sqy_q;
  logic signed [CX_W-1:0]   a_cx_q, a_cy_q, a_cx_d, a_cy_d;
  logic signed [ZW-1:0]     a_cz_q, a_cz_d;
  logic signed [HEAD_W-1:0] a_hd_q;
  logic signed [RAD_W-1:0]  sqx_full, sqy_full;
  logic signed [CX_W-1:0]   xe, ye;

  assign sqx_full = RAD_W'(item_i.dx) * RAD_W'(item_i.dx);
  assign sqy_full = RAD_W'(item_i.dy) * RAD_W'(item_i.dy);
  assign xe = CX_W'(signed'(item_i.dx)) <<< PAD_SHIFT;
  assign ye = CX_W'(signed'(item_i.dy)) <<< PAD_SHIFT;

  // A vector in the left half plane is turned by a quarter turn first.
  always_comb begin
    a_cx_d = xe;
    a_cy_d = ye;
    a_cz_d = '0;
    if (item_i.dx_neg) begin
      if (!item_i.dy_neg) begin
        a_cx_d = ye;
        a_cy_d = -xe;
        a_cz_d = HALF_PI;
      end else begin
        a_cx_d = -ye;
        a_cy_d = xe;
        a_cz_d = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sqx_q <= sqx_full[SQ_W-1:0];
    a_sqy_q <= sqy_full[SQ_W-1:0];
    a_cx_q  <= a_cx_d;
    a_cy_q  <= a_cy_d;
    a_cz_q  <= a_cz_d;
    a_hd_q  <= item_i.heading;
  end

  // Stage 1 adds the squares; stages 2 and up take one root bit each.
  // CORDIC iteration i runs alongside in stage i + 1.
  logic                     v_q  [1:NS];
  logic [RAD_W-1:0]         n_q  [1:NS];
  logic [ROOT_W-1:0]        q_q  [1:NS];
  logic [REM_W-1:0]         r_q  [1:NS];
  logic signed [CX_W-1:0]   cx_q [1:NS];
  logic signed [CX_W-1:0]   cy_q [1:NS];
  logic signed [ZW-1:0]     cz_q [1:NS];
  logic signed [HEAD_W-1:0] hd_q [1:NS];

  for (genvar j = 1; j <= NS; j++) begin : g_stage
    logic                     src_v;
    logic signed [CX_W-1:0]   src_cx, src_cy;
    logic signed [ZW-1:0]     src_cz;
    logic signed [HEAD_W-1:0] src_hd;
    logic [RAD_W-1:0]         n_d;
    logic [ROOT_W-1:0]        q_d;
    logic [REM_W-1:0]         r_d;
    logic signed [CX_W-1:0]   cx_d, cy_d;
    logic signed [ZW-1:0]     cz_d;

    if (j == 1) begin : g_src_entry
      assign src_v  = a_v_q;
      assign src_cx = a_cx_q;
      assign src_cy = a_cy_q;
      assign src_cz = a_cz_q;
      assign src_hd = a_hd_q;
      always_comb begin
        n_d = RAD_W'(a_sqx_q) + RAD_W'(a_sqy_q);
        q_d = '0;
        r_d = '0;
      end
    end else begin : g_src_chain
      logic [REM_W+1:0] rem_t, trial;
      assign src_v  = v_q[j-1];
      assign src_cx = cx_q[j-1];
      assign src_cy = cy_q[j-1];
      assign src_cz = cz_q[j-1];
      assign src_hd = hd_q[j-1];
      assign rem_t  = {r_q[j-1], n_q[j-1][RAD_W-1:RAD_W-2]};
      assign trial  = {1'b0, q_q[j-1], 2'b01};
      always_comb begin
        n_d = n_q[j-1] << 2;
        if (rem_t >= trial) begin
          r_d = REM_W'(rem_t - trial);
          q_d = {q_q[j-1][ROOT_W-2:0], 1'b1};
        end else begin
          r_d = rem_t[REM_W-1:0];
          q_d = {q_q[j-1][ROOT_W-2:0], 1'b0};
        end
      end
    end

    if (j - 1 < CN) begin : g_rot
      localparam logic signed [ZW-1:0] ATAN_C = ZW'(atan_frac(j - 1, FRAC_BITS));
      logic signed [CX_W-1:0] xs, ys;
      assign xs = src_cx >>> (j - 1);
      assign ys = src_cy >>> (j - 1);
      always_comb begin
        if (!src_cy[CX_W-1]) begin
          cx_d = src_cx + ys;
          cy_d = src_cy - xs;
          cz_d = src_cz + ATAN_C;
        end else begin
          cx_d = src_cx - ys;
          cy_d = src_cy + xs;
          cz_d = src_cz - ATAN_C;
        end
      end
    end else begin : g_hold
      assign cx_d = src_cx;
      assign cy_d = src_cy;
      assign cz_d = src_cz;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[j]  <= n_d;
      q_q[j]  <= q_d;
      r_q[j]  <= r_d;
      cx_q[j] <= cx_d;
      cy_q[j] <= cy_d;
      cz_q[j] <= cz_d;
      hd_q[j] <= src_hd;
    end
  end

  // Product stage: gain times distance, absolute heading error.
  logic               p_v_q;
  logic               p_far_q, p_far_d;
  logic [PROD_W-1:0]  p_prod_q, p_prod_d;
  logic [EW-1:0]      p_aerr_q, p_aerr_d;
  logic signed [EW-1:0] err;

  assign err      = EW'(cz_q[NS]) - EW'(hd_q[NS]);
  assign p_aerr_d = err[EW-1] ? EW'(-err) : EW'(err);
  assign p_prod_d = PROD_W'(cfg_i.gain) * PROD_W'(q_q[NS]);
  assign p_far_d  = (q_q[NS] > ROOT_W'(THR_DIST));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    p_far_q  <= p_far_d;
    p_prod_q <= p_prod_d;
    p_aerr_q <= p_aerr_d;
  end

  // Decision stage.
  logic [LIN_W-1:0]  lin_full;
  logic [SPD_W-1:0]  lin_sat, lin_d, lin_q;
  logic [TURN_W-1:0] turn_sat, turn_d, turn_q;
  logic              turning;
  logic              done_q;

  assign lin_full = p_prod_q[PROD_W-1:GAIN_FRAC];
  assign lin_sat  = (lin_full > LIN_W'(cfg_i.speed_limit)) ? cfg_i.speed_limit
                                                           : lin_full[SPD_W-1:0];
  assign turning  = (p_aerr_q > EW'(THR_TURN));
  assign turn_sat = (p_aerr_q > EW'(TURN_MAX)) ? '1 : p_aerr_q[TURN_W-1:0];

  always_comb begin
    lin_d  = '0;
    turn_d = '0;
    if (p_far_q) begin
      if (turning) begin
        turn_d = turn_sat;
      end else begin
        lin_d = lin_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lin_q  <= lin_d;
    turn_q <= turn_d;
  end

  assign done_o         = done_q;
  assign linear_speed_o = lin_q;
  assign turn_rate_o    = turn_q;

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (linear_speed_o == '0 || turn_rate_o == '0))
    else $error("drive and turn commanded together");

  a_speed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (linear_speed_o <= $past(cfg_i.speed_limit)))
    else $error("linear speed above its limit");

  a_turn_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && turn_rate_o != '0) |->
      (EW'(turn_rate_o) > EW'(THR_TURN) || turn_rate_o == '1))
    else $error("turn rate inside the straight-drive band");

endmodule
